FILE: rtl/ita_pkg.sv
`timescale 1ns / 1ps

package ita_pkg;

  // Conversion kinds as carried on the input tuser field.
  typedef enum logic [1:0] {
    KIND_DEC = 2'd0,
    KIND_HEX = 2'd1,
    KIND_BIN = 2'd2,
    KIND_PTR = 2'd3
  } kind_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_PFX0,
    S_PFXX,
    S_EMIT
  } state_t;

  localparam int VALUE_W   = 32;
  localparam int CHAR_W    = 7;
  localparam int BCD_DIGITS = 10;
  localparam int DIG_W     = 4 * BCD_DIGITS;
  localparam int CNT_W     = 6;

  localparam logic [CNT_W-1:0] CNT_CONV = CNT_W'(VALUE_W);
  localparam logic [CNT_W-1:0] CNT_DEC  = CNT_W'(BCD_DIGITS);
  localparam logic [CNT_W-1:0] CNT_HEX  = CNT_W'(VALUE_W / 4);
  localparam logic [CNT_W-1:0] CNT_BIN  = CNT_W'(VALUE_W);

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_X    = 7'h78;
  localparam logic [CHAR_W-1:0] CHAR_A    = 7'h61;

  // Map one digit value to its lowercase ASCII character.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A + CHAR_W'(d - 4'd10);
    end
    return c;
  endfunction

  // True when every nibble of a packed BCD word is a legal decimal digit.
  function automatic logic bcd_ok(input logic [DIG_W-1:0] w);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (w[4*i +: 4] > 4'd9) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

FILE: rtl/integer_to_ascii_radix.sv
`timescale 1ns / 1ps

// Channel  Direction  tdata                       tuser        tlast
// in_      slave      [31:0] value                [1:0] func   -
// out_     master     [6:0] char_code, [7] zero   -            last
//
// One request is taken while the sequencer is idle. Decimal first runs
// a shift-and-add-3 unit that builds ten BCD digits, one value bit a cycle.
// Every kind then drops leading zero digits at one digit a cycle (up to 9 for
// decimal, 7 for hex, 31 for binary) and emits one character a cycle while the
// output is not stalled: the prefix for pointer, then the digits. A stalled
// output holds the sequencer in place.
// Reset returns the sequencer to idle and empties the output register.
module integer_to_ascii_radix
  import ita_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [6:0] char_code, [7] zero fill
  output logic        out_tlast   // last
);

  state_t             state_r, state_nxt;
  kind_t              kind_r, kind_nxt;
  logic [VALUE_W-1:0] bin_r, bin_nxt;
  logic [DIG_W-1:0]   dig_r, dig_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  logic               in_accept;
  logic               out_free;
  logic [3:0]         top_digit;
  logic [DIG_W-1:0]   dig_shift;
  logic [DIG_W-1:0]   dig_adj;
  logic               skip_more;

  assign in_accept = in_tvalid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_tready;

  // Leading digit and the word with it shifted out, per kind.
  assign top_digit = (kind_r == KIND_BIN) ? {3'b000, dig_r[DIG_W-1]} : dig_r[DIG_W-1 -: 4];
  assign dig_shift = (kind_r == KIND_BIN) ? {dig_r[DIG_W-2:0], 1'b0}
                                          : {dig_r[DIG_W-5:0], 4'h0};
  assign skip_more = (top_digit == 4'h0) && (cnt_r > CNT_W'(1));

  // Add 3 to every BCD digit of 5 or more before the next shift.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (dig_r[4*i +: 4] >= 4'd5) begin
        dig_adj[4*i +: 4] = dig_r[4*i +: 4] + 4'd3;
      end else begin
        dig_adj[4*i +: 4] = dig_r[4*i +: 4];
      end
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = (kind_t'(in_tuser) == KIND_DEC) ? S_CONV : S_SKIP;
        end
      end
      S_CONV: begin
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        if (!skip_more) begin
          state_nxt = (kind_r == KIND_PTR) ? S_PFX0 : S_EMIT;
        end
      end
      S_PFX0: begin
        if (out_free) begin
          state_nxt = S_PFXX;
        end
      end
      S_PFXX: begin
        if (out_free) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free && (cnt_r == CNT_W'(1))) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    kind_nxt      = kind_r;
    bin_nxt       = bin_r;
    dig_nxt       = dig_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          kind_nxt = kind_t'(in_tuser);
          bin_nxt  = in_tdata;
          unique case (kind_t'(in_tuser))
            KIND_DEC: begin
              dig_nxt = '0;
              cnt_nxt = CNT_CONV;
            end
            KIND_BIN: begin
              dig_nxt = {in_tdata, 8'h00};
              cnt_nxt = CNT_BIN;
            end
            default: begin
              dig_nxt = {in_tdata, 8'h00};
              cnt_nxt = CNT_HEX;
            end
          endcase
        end
      end
      S_CONV: begin
        dig_nxt = {dig_adj[DIG_W-2:0], bin_r[VALUE_W-1]};
        bin_nxt = {bin_r[VALUE_W-2:0], 1'b0};
        cnt_nxt = (cnt_r == CNT_W'(1)) ? CNT_DEC : cnt_r - CNT_W'(1);
      end
      S_SKIP: begin
        if (skip_more) begin
          dig_nxt = dig_shift;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_PFX0: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_ZERO;
          out_last_nxt  = 1'b0;
        end
      end
      S_PFXX: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_X;
          out_last_nxt  = 1'b0;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_char(top_digit);
          out_last_nxt  = (cnt_r == CNT_W'(1));
          dig_nxt       = dig_shift;
          cnt_nxt       = cnt_r - CNT_W'(1);
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    bin_r      <= bin_nxt;
    dig_r      <= dig_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_char_r};
  assign out_tlast  = out_last_r;

  // The digit counter never runs out while a request is in progress.
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (cnt_r != '0))
    else $error("digit counter reached zero during a request");

  // The BCD word stays in range through the whole conversion.
  a_bcd_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CONV) |-> bcd_ok(dig_r))
    else $error("illegal BCD digit during decimal conversion");

  // Every emitted character is a digit, a lowercase hex letter or the x.
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_char_r >= CHAR_ZERO && out_char_r <= 7'h39) ||
                     (out_char_r >= CHAR_A && out_char_r <= 7'h66) ||
                     (out_char_r == CHAR_X)))
    else $error("emitted character outside the digit set");

  // Finishing loads a character flagged last and returns the sequencer to idle.
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_free && cnt_r == CNT_W'(1)) |=>
      (state_r == S_IDLE && out_valid_r && out_last_r))
    else $error("final character not flagged or sequencer not idle");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ita_pkg::*;

  // Stall patterns for the two sides of the block.
  localparam int MODE_NONE = 0;
  localparam int MODE_SEND = 1;
  localparam int MODE_RECV = 2;
  localparam int MODE_BOTH = 3;

  localparam int IDLE_HEAVY = 59;
  localparam int IDLE_LIGHT = 7;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT = 600000;

  localparam string DIGIT_CHARS = "0123456789abcdef";

  typedef struct {
    kind_t       kind;
    logic [31:0] value;
  } conv_req_t;

  typedef struct {
    logic [6:0] code;
    logic       last;
  } char_exp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] value
  logic [1:0]  in_tuser = '0;   // [1:0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [6:0] char_code, [7] zero fill
  logic        out_tlast;

  conv_req_t req_q[$];
  char_exp_t char_q[$];

  int  idle_mode = MODE_NONE;
  bit  hold_armed = 1'b0;
  bit  hold_used = 1'b0;
  int  hold_left = 0;
  bit  in_fire = 1'b0;
  int  errors = 0;
  int  cycle_count = 0;

  integer_to_ascii_radix i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Append the characters that one conversion request should produce.
  function automatic void predict_text(input kind_t kind, input logic [31:0] value);
    logic [3:0]  rev [32];
    logic [31:0] rest;
    logic [31:0] radix;
    int          nd;
    char_exp_t   ch;
    rest = value;
    nd = 0;
    case (kind)
      KIND_DEC: radix = 32'd10;
      KIND_BIN: radix = 32'd2;
      default:  radix = 32'd16;
    endcase
    // Digits come out least significant first; zero still gives one digit.
    do begin
      rev[nd] = 4'(rest % radix);
      rest = rest / radix;
      nd++;
    end while (rest != 0);
    if (kind == KIND_PTR) begin
      ch.code = 7'(DIGIT_CHARS[0]);
      ch.last = 1'b0;
      char_q.push_back(ch);
      ch.code = 7'h78;
      char_q.push_back(ch);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      ch.code = 7'(DIGIT_CHARS[rev[i]]);
      ch.last = (i == 0);
      char_q.push_back(ch);
    end
  endfunction

  // Roll whether one side idles this cycle under the current mode.
  function automatic bit idle_roll(input bit sender);
    int pct;
    pct = 0;
    if (idle_mode == MODE_BOTH) begin
      pct = IDLE_LIGHT;
    end else if ((sender && idle_mode == MODE_SEND) || (!sender && idle_mode == MODE_RECV)) begin
      pct = IDLE_HEAVY;
    end
    return $urandom_range(0, 99) < pct;
  endfunction

  // Driver: offers queued requests and holds each one until it is taken.
  always @(negedge clk) begin
    conv_req_t req;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (req_q.size() > 0 && !idle_roll(1'b1)) begin
        req = req_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= req.value;
        in_tuser <= req.kind;
      end else begin
        in_tvalid <= 1'b0;
        in_tdata <= $urandom();
        in_tuser <= 2'($urandom_range(0, 3));
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off when armed.
  always @(negedge clk) begin
    if (hold_armed && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && !idle_roll(1'b0);
    end
  end

  // Monitor: checks each character and predicts on each accepted request.
  always @(posedge clk) begin
    char_exp_t ch;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL integer_to_ascii_radix");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (char_q.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual tdata=%h tlast=%b",
                 $time, out_tdata, out_tlast);
        errors++;
      end else begin
        ch = char_q.pop_front();
        if (out_tdata !== {1'b0, ch.code}) begin
          $display("%0t: tdata mismatch: expected %h, actual %h",
                   $time, {1'b0, ch.code}, out_tdata);
          errors++;
        end
        if (out_tlast !== ch.last) begin
          $display("%0t: tlast mismatch: expected %b, actual %b",
                   $time, ch.last, out_tlast);
          errors++;
        end
      end
    end
    in_fire = rst_n && in_tvalid && in_tready;
    if (in_fire) begin
      predict_text(kind_t'(in_tuser), in_tdata);
    end
  end

  task automatic add_req(input kind_t kind, input logic [31:0] value);
    conv_req_t req;
    req.kind = kind;
    req.value = value;
    req_q.push_back(req);
  endtask

  // Random requests; the value length is spread by shifting a full word.
  task automatic add_random(input int n);
    logic [31:0] v;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: v = '0;
        1: v = '1;
        default: v = $urandom() >> $urandom_range(0, 31);
      endcase
      add_req(kind_t'($urandom_range(0, 3)), v);
    end
  endtask

  // Wait until every request has gone in and every character has come out.
  task automatic drain_wait();
    while (req_q.size() > 0 || in_tvalid || char_q.size() > 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero, one and all ones for every kind, then digit boundaries.
    idle_mode = MODE_NONE;
    add_req(KIND_DEC, 32'd0);
    add_req(KIND_HEX, 32'd0);
    add_req(KIND_BIN, 32'd0);
    add_req(KIND_PTR, 32'd0);
    add_req(KIND_DEC, 32'd1);
    add_req(KIND_HEX, 32'd1);
    add_req(KIND_BIN, 32'd1);
    add_req(KIND_PTR, 32'd1);
    add_req(KIND_DEC, '1);
    add_req(KIND_HEX, '1);
    add_req(KIND_BIN, '1);
    add_req(KIND_PTR, '1);
    add_req(KIND_DEC, 32'd9);
    add_req(KIND_DEC, 32'd10);
    add_req(KIND_DEC, 32'd999999999);
    add_req(KIND_DEC, 32'd1000000000);
    add_req(KIND_HEX, 32'h0000000f);
    add_req(KIND_HEX, 32'h00000010);
    add_req(KIND_HEX, 32'h80000000);
    add_req(KIND_BIN, 32'h80000000);
    add_req(KIND_BIN, 32'd2);
    add_req(KIND_PTR, 32'h00000010);
    add_req(KIND_PTR, 32'h0abcdef0);
    drain_wait();

    // Random requests under each stall pattern.
    idle_mode = MODE_NONE;
    add_random(70);
    drain_wait();
    idle_mode = MODE_SEND;
    add_random(70);
    drain_wait();
    idle_mode = MODE_RECV;
    add_random(70);
    drain_wait();
    idle_mode = MODE_BOTH;
    add_random(70);
    drain_wait();

    // Long receiver hold-off while the sender keeps offering.
    idle_mode = MODE_NONE;
    hold_armed = 1'b1;
    add_random(20);
    drain_wait();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS integer_to_ascii_radix");
    end else begin
      $display("FAIL integer_to_ascii_radix");
    end
    $finish;
  end

endmodule
